>>> rtl/swfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_pkg
// Shared types, constants and the CRC-8 step for the stop-and-wait sender.
// ----------------------------------------------------------------------------
package swfs_pkg;

  // input command codes, carried on in_tuser
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_RESP  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  // position within an outgoing five-byte frame
  typedef logic [2:0] beat_t;
  localparam beat_t BEAT_OPEN  = 3'd0;
  localparam beat_t BEAT_SEQ   = 3'd1;
  localparam beat_t BEAT_DATA  = 3'd2;
  localparam beat_t BEAT_CRC   = 3'd3;
  localparam beat_t BEAT_CLOSE = 3'd4;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] CRC_INIT  = 8'h00;

  // configuration registers and their reset values
  localparam logic       REG_TIMEOUT   = 1'b0;
  localparam logic       REG_ACK       = 1'b1;
  localparam logic [15:0] TIMEOUT_RST  = 16'd5000;
  localparam logic [7:0]  ACK_RST      = 8'h88;

  // frame request from the controller to the serialiser
  typedef struct packed {
    logic valid;
    logic retx;
    logic done;
  } req_t;

  // content of the current frame, held by the controller
  typedef struct packed {
    logic [7:0] seq_byte;
    logic [7:0] data;
    logic [7:0] seq_crc;
  } frame_t;

  // one byte through the CRC-8 register, MSB first, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/swfs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_store
// Message byte store: one write port, one registered read port with
// write-first forwarding when both hit the same entry.
// ----------------------------------------------------------------------------
module swfs_store #(
  parameter int MSG_DEPTH = 256,
  parameter int AW        = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [MSG_DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, newest data wins
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/swfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_ctrl
// ARQ controller: handles one accepted transaction per cycle, updates the
// send state and asks the serialiser for a frame or a completion notice.
// ----------------------------------------------------------------------------
module swfs_ctrl #(
  parameter int MSG_DEPTH   = 256,
  parameter int SEQ_MODULUS = 8,
  parameter int AW          = 8,
  parameter int IW          = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  swfs_pkg::cmd_t      command,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          byte_index,
  input  logic [8:0]          msg_length,
  input  logic [15:0]         timeout_ticks,
  input  logic [7:0]          ack_code,
  output logic                st_wr_en,
  output logic [AW-1:0]       st_wr_addr,
  output logic [7:0]          st_wr_data,
  output logic [AW-1:0]       st_rd_addr,
  input  logic [7:0]          st_rd_data,
  output swfs_pkg::req_t      req,
  output swfs_pkg::frame_t    frame
);

  localparam int SW = $clog2(SEQ_MODULUS);

  logic [IW-1:0] len_r,   len_nxt;
  logic [IW-1:0] idx_r,   idx_nxt;
  logic [SW-1:0] seq_r,   seq_nxt;
  logic [7:0]    data_r,  data_nxt;
  logic [7:0]    scrc_r,  scrc_nxt;
  logic          wait_r,  wait_nxt;
  logic [15:0]   tick_r,  tick_nxt;

  logic [IW-1:0] len_sat;
  logic [15:0]   tick_inc;
  logic          advance;
  logic [SW-1:0] seq_inc;

  // length clipped to the store depth
  always_comb begin
    if (32'(msg_length) > 32'(MSG_DEPTH)) begin
      len_sat = IW'(MSG_DEPTH);
    end else begin
      len_sat = IW'(msg_length);
    end
  end

  assign tick_inc = tick_r + 16'd1;
  assign seq_inc  = (seq_r == SW'(SEQ_MODULUS - 1)) ? '0 : seq_r + 1'b1;

  // transaction handling
  always_comb begin
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    wait_nxt  = wait_r;
    tick_nxt  = tick_r;
    advance   = 1'b0;
    req       = '0;
    if (acc) begin
      unique case (command)
        swfs_pkg::CMD_LOAD: begin
        end
        swfs_pkg::CMD_START: begin
          if (!wait_r && (msg_length != 9'd0)) begin
            len_nxt   = len_sat;
            idx_nxt   = IW'(1);
            advance   = 1'b1;
            wait_nxt  = 1'b1;
            tick_nxt  = '0;
            req.valid = 1'b1;
          end
        end
        swfs_pkg::CMD_RESP: begin
          if (wait_r) begin
            tick_nxt  = '0;
            req.valid = 1'b1;
            if (data_byte != ack_code) begin
              req.retx = 1'b1;
            end else if (idx_r >= len_r) begin
              wait_nxt = 1'b0;
              idx_nxt  = '0;
              req.done = 1'b1;
            end else begin
              idx_nxt = idx_r + 1'b1;
              advance = 1'b1;
            end
          end
        end
        swfs_pkg::CMD_TICK: begin
          if (wait_r) begin
            if (tick_inc >= timeout_ticks) begin
              tick_nxt  = '0;
              req.valid = 1'b1;
              req.retx  = 1'b1;
            end else begin
              tick_nxt = tick_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a new data frame takes the next sequence number and the prefetched byte
  assign seq_nxt  = advance ? seq_inc : seq_r;
  assign data_nxt = advance ? st_rd_data : data_r;
  assign scrc_nxt = advance ? swfs_pkg::crc8_byte(swfs_pkg::CRC_INIT, 8'(seq_inc)) : scrc_r;

  // store access: loads write, read follows the next send position
  always_comb begin
    st_wr_en   = acc && (command == swfs_pkg::CMD_LOAD) && (32'(byte_index) < 32'(MSG_DEPTH));
    st_wr_addr = AW'(byte_index);
    st_wr_data = data_byte;
    if (32'(idx_nxt) < 32'(MSG_DEPTH)) begin
      st_rd_addr = AW'(idx_nxt);
    end else begin
      st_rd_addr = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      idx_r  <= '0;
      seq_r  <= SW'(SEQ_MODULUS - 1);
      wait_r <= 1'b0;
      tick_r <= '0;
    end else begin
      len_r  <= len_nxt;
      idx_r  <= idx_nxt;
      seq_r  <= seq_nxt;
      wait_r <= wait_nxt;
      tick_r <= tick_nxt;
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    scrc_r <= scrc_nxt;
  end

  assign frame.seq_byte = 8'(seq_r);
  assign frame.data     = data_r;
  assign frame.seq_crc  = scrc_r;

endmodule

>>> rtl/swfs_ser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_ser
// Output serialiser: plays a frame out one byte per transaction, or a single
// completion notice, and finishes the frame CRC while the opening flag shows.
// ----------------------------------------------------------------------------
module swfs_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  swfs_pkg::req_t    req,
  input  swfs_pkg::frame_t  frame,
  output logic              ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  logic                  active_r, active_nxt;
  swfs_pkg::beat_t       beat_r,   beat_nxt;
  logic                  retx_r,   retx_nxt;
  logic                  done_r,   done_nxt;
  logic [7:0]            crc_r;
  logic                  last;
  logic                  take;
  logic [7:0]            byte_out;

  assign last  = done_r || (beat_r == swfs_pkg::BEAT_CLOSE);
  assign take  = active_r && out_tready;
  assign ready = !active_r || (take && last);

  // sequencing
  always_comb begin
    active_nxt = active_r;
    beat_nxt   = beat_r;
    retx_nxt   = retx_r;
    done_nxt   = done_r;
    if (req.valid) begin
      active_nxt = 1'b1;
      beat_nxt   = swfs_pkg::BEAT_OPEN;
      retx_nxt   = req.retx;
      done_nxt   = req.done;
    end else if (take) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      beat_r   <= swfs_pkg::BEAT_OPEN;
      retx_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      beat_r   <= beat_nxt;
      retx_r   <= retx_nxt;
      done_r   <= done_nxt;
    end
  end

  // second CRC byte, settled before the CRC beat
  always_ff @(posedge clk) begin
    if (active_r && (beat_r == swfs_pkg::BEAT_OPEN)) begin
      crc_r <= swfs_pkg::crc8_byte(frame.seq_crc, frame.data);
    end
  end

  // byte select
  always_comb begin
    byte_out = '0;
    if (!done_r) begin
      unique case (beat_r)
        swfs_pkg::BEAT_OPEN:  byte_out = swfs_pkg::FLAG_BYTE;
        swfs_pkg::BEAT_SEQ:   byte_out = frame.seq_byte;
        swfs_pkg::BEAT_DATA:  byte_out = frame.data;
        swfs_pkg::BEAT_CRC:   byte_out = crc_r;
        swfs_pkg::BEAT_CLOSE: byte_out = swfs_pkg::FLAG_BYTE;
        default:              byte_out = '0;
      endcase
    end
  end

  assign out_tvalid = active_r;
  assign out_tdata  = {7'd0, retx_r && !done_r, byte_out};
  assign out_tlast  = last;
  assign out_tuser  = done_r;

endmodule

>>> rtl/stop_and_wait_frame_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_frame_sender
// Stop-and-wait ARQ sender with CRC-8 framed data bytes.
// ----------------------------------------------------------------------------
// Load, start, response and tick transactions are taken one per cycle while
// in_tready is high; in_tready is low while output is pending, until its
// final byte is taken. A transaction that sends a frame produces five bytes
// on the output, one per cycle while out_tready is high; the next input
// transaction is taken in the cycle the closing flag is taken. The output
// serialiser is one byte wide. A completion notice is a single output
// transaction. The message store is a single-write, registered-read memory
// that prefetches the next byte to send, so no clearing pass is needed after
// reset. Registers: timeout_ticks at 0x0, ack_code at 0x4.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_sender #(
  parameter int MSG_DEPTH   = 256,
  parameter int SEQ_MODULUS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // data_byte [7:0], byte_index [15:8], msg_length [24:16], zero [31:25]
  input  logic [31:0] in_tdata,
  // command [1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_byte [7:0], is_retransmit [8], zero [15:9]
  output logic [15:0] out_tdata,
  // result_kind [0]
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int IW = $clog2(MSG_DEPTH + 1);

  logic [15:0]       timeout_r;
  logic [7:0]        ack_r;
  logic              acc;
  logic              cfg_wr;
  logic              st_wr_en;
  logic [AW-1:0]     st_wr_addr;
  logic [7:0]        st_wr_data;
  logic [AW-1:0]     st_rd_addr;
  logic [7:0]        st_rd_data;
  swfs_pkg::req_t    req;
  swfs_pkg::frame_t  frame;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= swfs_pkg::TIMEOUT_RST;
      ack_r     <= swfs_pkg::ACK_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == swfs_pkg::REG_ACK) begin
        ack_r <= cfg_pwdata[7:0];
      end else begin
        timeout_r <= cfg_pwdata[15:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == swfs_pkg::REG_ACK) ? {24'd0, ack_r} : {16'd0, timeout_r};

  assign acc = in_tvalid && in_tready;

  swfs_store #(
    .MSG_DEPTH (MSG_DEPTH),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  swfs_ctrl #(
    .MSG_DEPTH   (MSG_DEPTH),
    .SEQ_MODULUS (SEQ_MODULUS),
    .AW          (AW),
    .IW          (IW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .command       (swfs_pkg::cmd_t'(in_tuser)),
    .data_byte     (in_tdata[7:0]),
    .byte_index    (in_tdata[15:8]),
    .msg_length    (in_tdata[24:16]),
    .timeout_ticks (timeout_r),
    .ack_code      (ack_r),
    .st_wr_en      (st_wr_en),
    .st_wr_addr    (st_wr_addr),
    .st_wr_data    (st_wr_data),
    .st_rd_addr    (st_rd_addr),
    .st_rd_data    (st_rd_data),
    .req           (req),
    .frame         (frame)
  );

  swfs_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .frame      (frame),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/swfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_checker
// Port-level checks on the sender's output stream and input back-pressure.
// ----------------------------------------------------------------------------
module swfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output changed while stalled");

  // completion notice is a lone, zero, final transaction
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 16'd0))
    else $error("malformed completion notice");

  // no new input while a frame is part way out
  a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a frame");

  // a frame runs on without gaps
  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a frame");

  // with no new input, the stream goes quiet after the final byte
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("output without a cause");

endmodule

bind stop_and_wait_frame_sender swfs_checker u_swfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
